[hw/rtl/apm_pkg.sv]
// ----------------------------------------------------------------------------
// apm_pkg
// Shared widths, register indexes and controller/datapath link types for the
// averaging period meter.
// ----------------------------------------------------------------------------
package apm_pkg;

    // tick counter between edges, wraps
    localparam int PERIOD_COUNTER_WIDTH = 16;

    localparam int SUM_WIDTH     = 32;
    localparam int EDGE_WIDTH    = 24;
    localparam int OVF_WIDTH     = 8;
    localparam int NUM_WIDTH     = 16;
    localparam int DEN_WIDTH     = 20;
    localparam int RESULT_WIDTH  = 32;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 20;

    // mean + 1 needs one bit over the sum, product adds the scale width
    localparam int MEAN_WIDTH = SUM_WIDTH + 1;
    localparam int PROD_WIDTH = MEAN_WIDTH + NUM_WIDTH;

    // shared restoring divider, one quotient bit per cycle
    localparam int DIV_WIDTH     = PROD_WIDTH;
    localparam int DIV_STEPS     = DIV_WIDTH;
    localparam int DIVISOR_WIDTH = EDGE_WIDTH;
    localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS + 1);

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WINDOW_LIMIT = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SCALE_NUM    = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SCALE_DEN    = 2'd2;

    // register reset values
    localparam logic [OVF_WIDTH-1:0] WINDOW_LIMIT_RST = 8'd16;
    localparam logic [NUM_WIDTH-1:0] SCALE_NUM_RST    = 16'd24874;
    localparam logic [DEN_WIDTH-1:0] SCALE_DEN_RST    = 20'd100000;

    localparam logic [EDGE_WIDTH-1:0] EDGE_MAX = {EDGE_WIDTH{1'b1}};

    // controller to datapath
    typedef struct packed {
        logic step;      // an input beat is taken this cycle
        logic div_sum;   // start divider on period sum / edge count
        logic mul;       // register (mean + 1) * scale_num
        logic div_prod;  // start divider on product / scale_den
        logic load_out;  // load the result register
    } apm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic close;     // the offered beat closes a window
        logic zero_next; // that window saw no edges
        logic div_done;  // divider idle
    } apm_status_t;

endpackage

[hw/rtl/apm_if.sv]
// ----------------------------------------------------------------------------
// apm_if
// Valid/ready channels of the averaging period meter: tick beats in,
// window results out.
// ----------------------------------------------------------------------------
interface apm_tick_if;
    logic valid;
    logic ready;
    logic signal_edge;
    logic window_tick;

    modport source (output valid, output signal_edge, output window_tick, input ready);
    modport sink   (input valid, input signal_edge, input window_tick, output ready);
endinterface

interface apm_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] avg_period;
    logic        no_edges;

    modport source (output valid, output avg_period, output no_edges, input ready);
    modport sink   (input valid, input avg_period, input no_edges, output ready);
endinterface

[hw/rtl/apm_datapath.sv]
// ----------------------------------------------------------------------------
// apm_datapath
// Window accumulators, configuration registers, shared bit-serial divider,
// scale multiplier and result register.
// ----------------------------------------------------------------------------
module apm_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [apm_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [apm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  logic                                  signal_edge,
    input  logic                                  window_tick,
    input  apm_pkg::apm_cmd_t                     cmd,
    output apm_pkg::apm_status_t                  status,
    output logic [apm_pkg::RESULT_WIDTH-1:0]      avg_period,
    output logic                                  no_edges
);

    logic [apm_pkg::OVF_WIDTH-1:0]            limit_reg;
    logic [apm_pkg::NUM_WIDTH-1:0]            num_reg;
    logic [apm_pkg::DEN_WIDTH-1:0]            den_reg;

    logic [apm_pkg::PERIOD_COUNTER_WIDTH-1:0] period_reg, period_next;
    logic [apm_pkg::SUM_WIDTH-1:0]            sum_reg, sum_next;
    logic [apm_pkg::EDGE_WIDTH-1:0]           edges_reg, edges_next;
    logic [apm_pkg::OVF_WIDTH-1:0]            ovf_reg, ovf_next;
    logic                                     close;

    logic [apm_pkg::SUM_WIDTH-1:0]            snap_sum_reg;
    logic [apm_pkg::EDGE_WIDTH-1:0]           snap_edges_reg;
    logic                                     snap_zero_reg;

    logic [apm_pkg::DIV_WIDTH-1:0]            dvd_reg;
    logic [apm_pkg::DIVISOR_WIDTH-1:0]        rem_reg;
    logic [apm_pkg::DIVISOR_WIDTH-1:0]        dvs_reg;
    logic [apm_pkg::DIV_CNT_WIDTH-1:0]        div_cnt_reg;
    logic [apm_pkg::DIVISOR_WIDTH:0]          trial;
    logic                                     fits;

    logic [apm_pkg::MEAN_WIDTH-1:0]           mean;
    logic [apm_pkg::PROD_WIDTH-1:0]           prod_reg;
    logic [apm_pkg::RESULT_WIDTH-1:0]         sat_q;

    logic [apm_pkg::RESULT_WIDTH-1:0]         avg_period_reg;
    logic                                     no_edges_reg;

    // configuration registers, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= apm_pkg::WINDOW_LIMIT_RST;
            num_reg   <= apm_pkg::SCALE_NUM_RST;
            den_reg   <= apm_pkg::SCALE_DEN_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == apm_pkg::CFG_WINDOW_LIMIT)
                limit_reg <= cfg_data[apm_pkg::OVF_WIDTH-1:0];
            else if (cfg_index == apm_pkg::CFG_SCALE_NUM)
                num_reg <= cfg_data[apm_pkg::NUM_WIDTH-1:0];
            else if (cfg_index == apm_pkg::CFG_SCALE_DEN)
                den_reg <= cfg_data[apm_pkg::DEN_WIDTH-1:0];
        end
    end

    // per-tick update: edge first, then window timer
    always_comb
    begin
        if (signal_edge)
        begin
            sum_next    = sum_reg + apm_pkg::SUM_WIDTH'(period_reg);
            edges_next  = (edges_reg != apm_pkg::EDGE_MAX) ? edges_reg + 1'b1 : edges_reg;
            period_next = '0;
        end
        else
        begin
            sum_next    = sum_reg;
            edges_next  = edges_reg;
            period_next = period_reg + 1'b1;
        end
        ovf_next = window_tick ? ovf_reg + 1'b1 : ovf_reg;
        close    = window_tick && (ovf_next >= limit_reg);
    end

    assign status.close     = close;
    assign status.zero_next = (edges_next == '0);
    assign status.div_done  = (div_cnt_reg == '0);

    // window accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            sum_reg    <= '0;
            edges_reg  <= '0;
            ovf_reg    <= '0;
        end
        else if (cmd.step)
        begin
            period_reg <= period_next;
            if (close)
            begin
                sum_reg   <= '0;
                edges_reg <= '0;
                ovf_reg   <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                edges_reg <= edges_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // snapshot of the closing window
    always_ff @(posedge clk)
    begin
        if (cmd.step && close)
        begin
            snap_sum_reg   <= sum_next;
            snap_edges_reg <= edges_next;
            snap_zero_reg  <= (edges_next == '0);
        end
    end

    // restoring divider step
    assign trial = {rem_reg, dvd_reg[apm_pkg::DIV_WIDTH-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.div_sum || cmd.div_prod)
            div_cnt_reg <= apm_pkg::DIV_CNT_WIDTH'(apm_pkg::DIV_STEPS);
        else if (div_cnt_reg != '0)
            div_cnt_reg <= div_cnt_reg - 1'b1;
    end

    // a zero divisor leaves all ones, which saturates below
    always_ff @(posedge clk)
    begin
        if (cmd.div_sum)
        begin
            dvd_reg <= apm_pkg::DIV_WIDTH'(snap_sum_reg);
            dvs_reg <= snap_edges_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_prod)
        begin
            dvd_reg <= prod_reg;
            dvs_reg <= apm_pkg::DIVISOR_WIDTH'(den_reg);
            rem_reg <= '0;
        end
        else if (div_cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[apm_pkg::DIV_WIDTH-2:0], fits};
            rem_reg <= fits ? apm_pkg::DIVISOR_WIDTH'(trial - {1'b0, dvs_reg})
                            : trial[apm_pkg::DIVISOR_WIDTH-1:0];
        end
    end

    // scale multiply on mean + 1
    assign mean = apm_pkg::MEAN_WIDTH'(dvd_reg[apm_pkg::SUM_WIDTH-1:0]) + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= apm_pkg::PROD_WIDTH'(mean) * apm_pkg::PROD_WIDTH'(num_reg);
    end

    // saturate quotient to result width
    assign sat_q = (dvd_reg[apm_pkg::DIV_WIDTH-1:apm_pkg::RESULT_WIDTH] != '0)
                 ? {apm_pkg::RESULT_WIDTH{1'b1}} : dvd_reg[apm_pkg::RESULT_WIDTH-1:0];

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            avg_period_reg <= snap_zero_reg ? '0 : sat_q;
            no_edges_reg   <= snap_zero_reg;
        end
    end

    assign avg_period = avg_period_reg;
    assign no_edges   = no_edges_reg;

endmodule

[hw/rtl/apm_ctrl.sv]
// ----------------------------------------------------------------------------
// apm_ctrl
// Sequencer for the averaging period meter: takes tick beats, runs the two
// divisions and the multiply on a window close, owns the result valid.
// ----------------------------------------------------------------------------
module apm_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  apm_pkg::apm_status_t  status,
    output apm_pkg::apm_cmd_t     cmd
);

    localparam logic [2:0] S_RUN     = 3'd0;
    localparam logic [2:0] S_DIV1_GO = 3'd1;
    localparam logic [2:0] S_DIV1    = 3'd2;
    localparam logic [2:0] S_MUL     = 3'd3;
    localparam logic [2:0] S_DIV2_GO = 3'd4;
    localparam logic [2:0] S_DIV2    = 3'd5;
    localparam logic [2:0] S_LOAD    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       take;
    logic       out_free;

    assign in_ready = (state_reg == S_RUN);
    assign take     = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.step     = take;
        unique case (state_reg)
            S_RUN:
            begin
                if (take && status.close)
                    state_next = status.zero_next ? S_LOAD : S_DIV1_GO;
            end
            S_DIV1_GO:
            begin
                cmd.div_sum = 1'b1;
                state_next  = S_DIV1;
            end
            S_DIV1:
            begin
                if (status.div_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV2_GO;
            end
            S_DIV2_GO:
            begin
                cmd.div_prod = 1'b1;
                state_next   = S_DIV2;
            end
            S_DIV2:
            begin
                if (status.div_done)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_RUN;
                end
            end
            default:
                state_next = S_RUN;
        endcase
    end

    // result valid: set on load, cleared when the beat is taken
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/averaging_period_meter.sv]
// ----------------------------------------------------------------------------
// averaging_period_meter
// Averages the period of a measured signal over a window of timer overflows
// and emits the scaled mean once per window.
// ----------------------------------------------------------------------------
// Usage:
//   sample: one beat per tick of the measuring clock, carrying signal_edge
//   and window_tick. A beat that does not close a window is taken back
//   to back, even while a result waits on the output.
//   result: one beat per closed window, avg_period and no_edges.
//   Closing a window with edges loads the shared bit-serial divider for
//   sum / edges (a load, then 49 steps), one multiply by scale_num, then
//   product / scale_den on the same divider (a load, then 49 steps). The
//   result is valid once the second division is done and the result
//   register is free; sample is held off until then. A window without edges
//   loads its result without a division, also holding sample off until then.
//   If the receiver stalls, the result register holds and a finished next
//   result waits in the controller, holding off sample, until it is free.
//   Configuration writes take effect at once and are meant for idle time.
//   Reset clears the accumulators, drops any result and restores the
//   register defaults (limit 16, scale 24874 / 100000).
// ----------------------------------------------------------------------------
module averaging_period_meter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [apm_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [apm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    apm_tick_if.sink                            sample,
    apm_result_if.source                        result
);

    apm_pkg::apm_cmd_t    cmd;
    apm_pkg::apm_status_t status;

    // sequencer
    apm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // accumulators and arithmetic
    apm_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .signal_edge (sample.signal_edge),
        .window_tick (sample.window_tick),
        .cmd         (cmd),
        .status      (status),
        .avg_period  (result.avg_period),
        .no_edges    (result.no_edges)
    );

endmodule
